/* src/baat_pkg.sv */
`default_nettype none

package baat_pkg;

  localparam int MAX_AREAS = 16;
  localparam int COUNT_W   = $clog2(MAX_AREAS + 1);

  // byte length is paragraphs * 16, offset + length end of an entry
  localparam int LEN_W = 20;
  localparam int END_W = 17;
  localparam int ALN_W = 21;

  localparam logic [END_W-1:0] FIRST_OFFSET   = END_W'(32'h100);
  localparam logic [31:0]      SEG_LIMIT      = 32'h0000_FFFF;
  localparam logic [LEN_W-1:0] MIN_ALIGN_MASK = LEN_W'(32'hF);
  localparam logic [31:0]      RES_INVALID    = 32'hFFFF_FFFF;
  localparam logic [31:0]      RES_NO_MATCH   = 32'h0000_0001;

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FIND  = 2'd1,
    ACT_FREE  = 2'd2,
    ACT_BAD   = 2'd3
  } action_e;

  typedef struct packed {
    logic [31:0] handle;
    logic [15:0] offset;
    logic [15:0] length;
  } entry_t;

  // search token that walks down the row of cells
  typedef struct packed {
    logic             vld;
    logic             hit;    // some live handle matched (last one wins)
    logic             found;  // a live offset matched at or before this cell
    logic [15:0]      off;    // offset of the last handle match
    logic [END_W-1:0] fin;    // end of the last live entry seen so far
  } pkt_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic        free_en;
    logic [31:0] key_handle;
    logic [15:0] key_off;
    logic        wr_en;
    entry_t      wr_entry;
    logic        shift_en;
  } cmd_t;

endpackage

`default_nettype wire

/* src/bump_area_allocator_table_top.sv */
// One item at a time: a new input transfer is taken only while the controller is idle.
// The search token walks the 16-cell row one cell per cycle, then the align,
// commit and output steps follow in that order.
// A result that is not taken holds the next item in its final step.
// Reset (async, active low) empties the table, zeroes the count and the segment.
`default_nettype none

module bump_area_allocator_table_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  action_i,
  input  wire logic [15:0] length_paragraphs_i,
  input  wire logic [31:0] area_handle_i,
  input  wire logic [15:0] request_flags_i,
  input  wire logic [31:0] area_address_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      return_value_o
);
  import baat_pkg::*;

  cmd_t   cmd;
  pkt_t   pkt     [MAX_AREAS+1];
  entry_t entries [MAX_AREAS+1];
  logic   lives   [MAX_AREAS+1];

  // past the last cell: an empty slot
  assign entries[MAX_AREAS] = '0;
  assign lives[MAX_AREAS]   = 1'b0;

  baat_ctrl u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .action_i            (action_i),
    .length_paragraphs_i (length_paragraphs_i),
    .area_handle_i       (area_handle_i),
    .request_flags_i     (request_flags_i),
    .area_address_i      (area_address_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .return_value_o      (return_value_o),
    .cmd_o               (cmd),
    .pkt_o               (pkt[0]),
    .pkt_i               (pkt[MAX_AREAS])
  );

  for (genvar i = 0; i < MAX_AREAS; i++) begin : g_cell
    logic left_live;
    if (i == 0) begin : g_head
      assign left_live = 1'b1;
    end else begin : g_body
      assign left_live = lives[i-1];
    end

    baat_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .pkt_i         (pkt[i]),
      .pkt_o         (pkt[i+1]),
      .left_live_i   (left_live),
      .right_entry_i (entries[i+1]),
      .right_live_i  (lives[i+1]),
      .entry_o       (entries[i]),
      .live_o        (lives[i])
    );
  end

endmodule

`default_nettype wire

/* src/baat_cell.sv */
`default_nettype none

module baat_cell (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire baat_pkg::cmd_t   cmd_i,
  input  wire baat_pkg::pkt_t   pkt_i,
  output baat_pkg::pkt_t        pkt_o,
  input  wire logic             left_live_i,
  input  wire baat_pkg::entry_t right_entry_i,
  input  wire logic             right_live_i,
  output baat_pkg::entry_t      entry_o,
  output logic                  live_o
);
  import baat_pkg::*;

  entry_t entry_q;
  logic   live_q;
  logic   mark_q;
  pkt_t   pkt_q;
  pkt_t   pkt_d;
  logic   m_find;
  logic   m_free;
  logic   do_shift;
  logic   do_write;

  assign m_find   = live_q && (entry_q.handle == cmd_i.key_handle);
  assign m_free   = live_q && cmd_i.free_en && (entry_q.offset == cmd_i.key_off);
  assign do_shift = cmd_i.shift_en && mark_q;
  // live bits form a prefix, so the first free slot is the one after a live cell
  assign do_write = cmd_i.wr_en && !live_q && left_live_i;

  always_comb begin
    pkt_d       = pkt_i;
    pkt_d.hit   = pkt_i.hit || m_find;
    pkt_d.found = pkt_i.found || m_free;
    if (m_find) begin
      pkt_d.off = entry_q.offset;
    end
    if (live_q) begin
      pkt_d.fin = {1'b0, entry_q.offset} + {1'b0, entry_q.length};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live_q <= 1'b0;
      mark_q <= 1'b0;
      pkt_q  <= '0;
    end else begin
      pkt_q <= pkt_d;
      if (do_shift) begin
        live_q <= right_live_i;
        mark_q <= 1'b0;
      end else if (do_write) begin
        live_q <= 1'b1;
      end
      // mark this cell and all after the removed entry
      if (pkt_i.vld) begin
        mark_q <= pkt_d.found;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_shift) begin
      entry_q <= right_entry_i;
    end else if (do_write) begin
      entry_q <= cmd_i.wr_entry;
    end
  end

  assign pkt_o   = pkt_q;
  assign entry_o = entry_q;
  assign live_o  = live_q;

endmodule

`default_nettype wire

/* src/baat_ctrl.sv */
`default_nettype none

module baat_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [1:0]     action_i,
  input  wire logic [15:0]    length_paragraphs_i,
  input  wire logic [31:0]    area_handle_i,
  input  wire logic [15:0]    request_flags_i,
  input  wire logic [31:0]    area_address_i,
  input  wire logic           cfg_valid_i,
  output logic                cfg_ready_o,
  input  wire logic [15:0]    cfg_data_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output logic [31:0]         return_value_o,
  output baat_pkg::cmd_t      cmd_o,
  output baat_pkg::pkt_t      pkt_o,
  input  wire baat_pkg::pkt_t pkt_i
);
  import baat_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LAUNCH = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_ALIGN  = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;
  localparam logic [2:0] ST_FINISH = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [1:0]         act_q;
  logic [LEN_W-1:0]   len_q;
  logic [31:0]        handle_q;
  logic               flag_conv_q;
  logic               flag_align_q;
  logic [31:0]        addr_q;
  logic [15:0]        seg_q;
  logic [COUNT_W-1:0] count_q;
  logic [LEN_W-1:0]   mask_q;
  logic               hit_q;
  logic               found_q;
  logic [15:0]        hit_off_q;
  logic [END_W-1:0]   next_q;
  logic [ALN_W-1:0]   aligned_q;
  logic [31:0]        res_q;
  logic               out_valid_q;
  logic [31:0]        out_data_q;

  logic               in_xfer;
  logic               out_load;
  logic [LEN_W-1:0]   lowbit;
  logic [LEN_W-1:0]   mask_d;
  logic [ALN_W:0]     fit_sum;
  logic               alloc_ok;
  logic               is_alloc;
  logic               is_free;
  logic [31:0]        res_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  assign lowbit = len_q & (~len_q + LEN_W'(1));
  assign mask_d = flag_align_q ? (lowbit - LEN_W'(1)) : MIN_ALIGN_MASK;

  assign fit_sum  = {1'b0, aligned_q} + (ALN_W + 1)'(len_q);
  assign is_alloc = (action_e'(act_q) == ACT_ALLOC);
  assign is_free  = (action_e'(act_q) == ACT_FREE);
  assign alloc_ok = flag_conv_q && (count_q < COUNT_W'(MAX_AREAS)) && (len_q != '0) &&
                    (fit_sum <= (ALN_W + 1)'(SEG_LIMIT));

  always_comb begin
    res_d = RES_INVALID;
    unique case (action_e'(act_q))
      ACT_ALLOC: begin
        if (!flag_conv_q || (count_q >= COUNT_W'(MAX_AREAS))) begin
          res_d = '0;
        end else if (len_q == '0) begin
          res_d = SEG_LIMIT - 32'(next_q);
        end else if (alloc_ok) begin
          res_d = {seg_q, aligned_q[15:0]};
        end else begin
          res_d = '0;
        end
      end
      ACT_FIND: res_d = hit_q ? {seg_q, hit_off_q} : '0;
      ACT_FREE: res_d = found_q ? '0 : RES_NO_MATCH;
      default:  res_d = RES_INVALID;
    endcase
  end

  always_comb begin
    cmd_o                 = '0;
    cmd_o.free_en         = is_free && (addr_q[31:16] == seg_q);
    cmd_o.key_handle      = handle_q;
    cmd_o.key_off         = addr_q[15:0];
    cmd_o.wr_entry.handle = handle_q;
    cmd_o.wr_entry.offset = aligned_q[15:0];
    cmd_o.wr_entry.length = len_q[15:0];
    cmd_o.wr_en           = (state_q == ST_COMMIT) && is_alloc && alloc_ok;
    cmd_o.shift_en        = (state_q == ST_COMMIT) && is_free && found_q;
  end

  always_comb begin
    pkt_o     = '0;
    pkt_o.vld = (state_q == ST_LAUNCH);
    pkt_o.fin = FIRST_OFFSET;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_xfer) state_d = ST_LAUNCH;
      ST_LAUNCH: state_d = ST_SCAN;
      ST_SCAN:   if (pkt_i.vld) state_d = ST_ALIGN;
      ST_ALIGN:  state_d = ST_COMMIT;
      ST_COMMIT: state_d = ST_FINISH;
      ST_FINISH: if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seg_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        seg_q <= cfg_data_i;
      end
      if (cmd_o.wr_en) begin
        count_q <= count_q + COUNT_W'(1);
      end else if (cmd_o.shift_en) begin
        count_q <= count_q - COUNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      act_q        <= action_i;
      len_q        <= {length_paragraphs_i, 4'b0000};
      handle_q     <= area_handle_i;
      flag_conv_q  <= request_flags_i[0];
      flag_align_q <= request_flags_i[2];
      addr_q       <= area_address_i;
    end
    if (state_q == ST_LAUNCH) begin
      mask_q <= mask_d;
    end
    if ((state_q == ST_SCAN) && pkt_i.vld) begin
      hit_q     <= pkt_i.hit;
      found_q   <= pkt_i.found;
      hit_off_q <= pkt_i.off;
      next_q    <= pkt_i.fin;
    end
    if (state_q == ST_ALIGN) begin
      // round up to the alignment
      aligned_q <= (ALN_W'(next_q) + ALN_W'(mask_q)) & ~ALN_W'(mask_q);
    end
    if (state_q == ST_COMMIT) begin
      res_q <= res_d;
    end
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign return_value_o = out_data_q;

endmodule

`default_nettype wire

/* src/baat_checker.sv */
`default_nettype none

module baat_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic [1:0]  action_i,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [31:0] return_value_o
);
  import baat_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_o;

  // one item at a time
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("input accepted while an item is in flight");

  a_result_arrives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##21 out_valid_o)
    else $error("no result after the fixed latency");

  a_invalid_function: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (action_i == ACT_BAD) && !out_valid_o) |->
      ##21 (out_valid_o && (return_value_o == RES_INVALID)))
    else $error("invalid function did not return all ones");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(return_value_o)))
    else $error("stalled result dropped or changed");

endmodule

bind bump_area_allocator_table_top baat_checker u_baat_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .action_i       (action_i),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .return_value_o (return_value_o)
);

`default_nettype wire

/* dv/bump_area_allocator_table_top_tb.sv */
module bump_area_allocator_table_top_tb;
  import baat_pkg::*;

  localparam logic [31:0] FIRST_OFF  = 32'h0000_0100;
  localparam logic [31:0] MIN_ALIGN  = 32'h0000_0010;
  localparam int          FLAG_CONV  = 0;
  localparam int          FLAG_ALIGN = 2;
  localparam int          PHASE_LEN  = 200;
  localparam int          SETTLE     = 25;

  typedef struct packed {
    action_e     action;
    logic [15:0] paras;
    logic [31:0] handle;
    logic [15:0] flags;
    logic [31:0] addr;
  } area_req_t;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  area_req_t   cur_req   = '0;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [15:0] cfg_data  = '0;

  logic        in_ready_o;
  logic        cfg_ready_o;
  logic        out_valid_o;
  logic [31:0] return_value_o;

  // shadow of the allocator state
  entry_t      area_tbl [MAX_AREAS];
  int unsigned area_cnt = 0;
  logic [15:0] seg_q    = '0;

  area_req_t   req_q [$];
  logic [31:0] ret_q [$];
  int unsigned n_sent = 0;
  int unsigned n_taken = 0;
  int unsigned err_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  logic        drv_vld_nxt;
  logic [31:0] drv_ret;
  logic [31:0] mon_want;

  bump_area_allocator_table_top u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid),
    .in_ready_o          (in_ready_o),
    .action_i            (cur_req.action),
    .length_paragraphs_i (cur_req.paras),
    .area_handle_i       (cur_req.handle),
    .request_flags_i     (cur_req.flags),
    .area_address_i      (cur_req.addr),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready),
    .return_value_o      (return_value_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Applies one request to the shadow table and yields the return value.
  task automatic serve_request(input area_req_t rq, output logic [31:0] rv);
    logic [31:0] len;
    logic [31:0] nxt;
    logic [31:0] aln;
    logic [31:0] off;
    int          hit;
    rv = '0;
    case (rq.action)
      ACT_ALLOC: begin
        len = {12'b0, rq.paras, 4'b0};
        nxt = FIRST_OFF;
        aln = MIN_ALIGN;
        if (rq.flags[FLAG_CONV] && area_cnt < MAX_AREAS) begin
          if (area_cnt != 0)
            nxt = 32'(area_tbl[area_cnt-1].offset) + 32'(area_tbl[area_cnt-1].length);
          if (len == '0) begin
            rv = SEG_LIMIT - nxt;
          end else begin
            if (rq.flags[FLAG_ALIGN]) begin
              aln = len & (~len + 32'd1);
              if (aln < MIN_ALIGN) aln = MIN_ALIGN;
            end
            if ((nxt & (aln - 32'd1)) != '0) nxt = (nxt + aln) & ~(aln - 32'd1);
            if (nxt + len <= SEG_LIMIT) begin
              area_tbl[area_cnt].handle = rq.handle;
              area_tbl[area_cnt].offset = nxt[15:0];
              area_tbl[area_cnt].length = len[15:0];
              area_cnt++;
              rv = {seg_q, nxt[15:0]};
            end
          end
        end
      end
      ACT_FIND: begin
        for (int k = 0; k < area_cnt; k++)
          if (area_tbl[k].handle == rq.handle) rv = {seg_q, area_tbl[k].offset};
      end
      ACT_FREE: begin
        off = rq.addr ^ {seg_q, 16'h0};
        hit = -1;
        for (int k = 0; k < area_cnt; k++)
          if (hit < 0 && {16'h0, area_tbl[k].offset} == off) hit = k;
        if (hit < 0) begin
          rv = RES_NO_MATCH;
        end else begin
          for (int k = hit; k + 1 < area_cnt; k++) area_tbl[k] = area_tbl[k+1];
          area_cnt--;
          area_tbl[area_cnt] = '0;
        end
      end
      default: rv = RES_INVALID;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("ERROR %s: return_value %08h expected %08h", what, got, want);
    err_cnt++;
  endtask

  // input driver: predicts on every transfer, then picks up the next pending item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      drv_vld_nxt = in_valid;
      if (in_valid && in_ready_o) begin
        serve_request(cur_req, drv_ret);
        ret_q.push_back(drv_ret);
        n_taken++;
        drv_vld_nxt = 1'b0;
      end
      if (!drv_vld_nxt && req_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_req <= req_q.pop_front();
        n_sent++;
        drv_vld_nxt = 1'b1;
      end
      in_valid <= drv_vld_nxt;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (ret_q.size() == 0) begin
          report_mismatch("unexpected result", return_value_o, '0);
        end else begin
          mon_want = ret_q.pop_front();
          if (return_value_o !== mon_want)
            report_mismatch("wrong result", return_value_o, mon_want);
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic area_req_t mk_req(action_e act, logic [15:0] paras,
                                       logic [31:0] handle, logic [15:0] flags,
                                       logic [31:0] addr);
    area_req_t rq;
    rq.action = act;
    rq.paras  = paras;
    rq.handle = handle;
    rq.flags  = flags;
    rq.addr   = addr;
    return rq;
  endfunction

  // Mostly legal traffic aimed at live entries; drain mode favours frees to empty the table.
  function automatic area_req_t random_request(bit drain);
    area_req_t   rq;
    int unsigned pick;
    int unsigned sel;
    int unsigned alloc_top;
    int unsigned find_top;
    rq.action = action_e'($urandom_range(3));
    rq.paras  = 16'($urandom);
    rq.handle = $urandom;
    rq.flags  = 16'($urandom);
    rq.addr   = $urandom;
    alloc_top = drain ? 20 : (area_cnt >= MAX_AREAS ? 30 : 58);
    find_top  = alloc_top + 17;
    pick = $urandom_range(99);
    if (pick < 4) begin
      rq.action = ACT_BAD;
    end else if (pick < alloc_top) begin
      rq.action = ACT_ALLOC;
      if ($urandom_range(9) != 0) rq.flags[FLAG_CONV] = 1'b1;
      sel = $urandom_range(19);
      if (sel == 0) rq.paras = '0;
      else if (sel == 2) rq.paras = 16'h1 << $urandom_range(15);
      else if (sel != 1) rq.paras = 16'($urandom_range(48, 1));
      if ($urandom_range(3) == 0) rq.handle = $urandom_range(7);
    end else if (pick < find_top) begin
      rq.action = ACT_FIND;
      if (area_cnt != 0 && $urandom_range(3) != 0)
        rq.handle = area_tbl[$urandom_range(area_cnt - 1)].handle;
      else if ($urandom_range(1) != 0)
        rq.handle = $urandom_range(7);
    end else begin
      rq.action = ACT_FREE;
      if (area_cnt != 0 && $urandom_range(4) != 0)
        rq.addr = {seg_q, area_tbl[$urandom_range(area_cnt - 1)].offset};
      else if ($urandom_range(1) != 0)
        rq.addr[31:16] = seg_q;
    end
    return rq;
  endfunction

  task automatic wait_idle();
    while (req_q.size() != 0 || n_sent != n_taken || ret_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_segment(input logic [15:0] val);
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    seg_q = val;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] seg_d;
    logic [31:0] hnd_a;
    bit          drain;
    seg_d = 16'h8001;
    hnd_a = 32'hFFFF_FFFE;
    drain = 1'b0;
    for (int k = 0; k < MAX_AREAS; k++) area_tbl[k] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_segment(seg_d);

    req_q.push_back(mk_req(ACT_BAD,   16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    req_q.push_back(mk_req(ACT_FIND,  16'h0,    32'h0,         16'h0,    32'h0));
    req_q.push_back(mk_req(ACT_FREE,  16'h0,    32'h0,         16'h0,    {seg_d, 16'h0100}));
    // extended memory request
    req_q.push_back(mk_req(ACT_ALLOC, 16'h4,    32'h1,         16'hFFFE, 32'h0));
    // free space query on empty table
    req_q.push_back(mk_req(ACT_ALLOC, 16'h0,    32'h1,         16'h0001, 32'h0));
    req_q.push_back(mk_req(ACT_ALLOC, 16'h1,    hnd_a,         16'h0001, 32'h0));
    req_q.push_back(mk_req(ACT_ALLOC, 16'h3,    32'h0,         16'h0005, 32'h0));
    req_q.push_back(mk_req(ACT_ALLOC, 16'h10,   hnd_a,         16'h0005, 32'h0));
    // no room: plain and with huge alignment
    req_q.push_back(mk_req(ACT_ALLOC, 16'hFFFF, 32'h2,         16'h0001, 32'h0));
    req_q.push_back(mk_req(ACT_ALLOC, 16'h8000, 32'h2,         16'hFFFF, 32'h0));
    req_q.push_back(mk_req(ACT_ALLOC, 16'h0,    32'h2,         16'h0001, 32'h0));
    // duplicate handle: last entry wins
    req_q.push_back(mk_req(ACT_FIND,  16'h0,    hnd_a,         16'h0,    32'h0));
    req_q.push_back(mk_req(ACT_FIND,  16'h0,    32'hFFFF_FFFF, 16'h0,    32'h0));
    // right offset, wrong segment
    req_q.push_back(mk_req(ACT_FREE,  16'h0,    32'h0,         16'h0,    {~seg_d, 16'h0110}));
    req_q.push_back(mk_req(ACT_FREE,  16'h0,    32'h0,         16'h0,    {seg_d, 16'h0110}));
    req_q.push_back(mk_req(ACT_FREE,  16'h0,    32'h0,         16'h0,    {seg_d, 16'h0110}));
    // fill up to the last whole paragraph of the segment, then no room and small free space
    req_q.push_back(mk_req(ACT_ALLOC, 16'h0FCF, 32'h3,         16'h0001, 32'h0));
    req_q.push_back(mk_req(ACT_ALLOC, 16'h1,    32'h3,         16'h0001, 32'h0));
    req_q.push_back(mk_req(ACT_ALLOC, 16'h0,    32'h3,         16'h0001, 32'h0));
    req_q.push_back(mk_req(ACT_FREE,  16'h0,    32'h0,         16'h0,    {seg_d, 16'h0300}));
    req_q.push_back(mk_req(ACT_FREE,  16'h0,    32'h0,         16'h0,    {seg_d, 16'h0100}));
    req_q.push_back(mk_req(ACT_FREE,  16'h0,    32'h0,         16'h0,    {seg_d, 16'h0200}));
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  seg_d = 16'h0000; end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  seg_d = 16'hFFFF; end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; seg_d = 16'($urandom); end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; seg_d = 16'($urandom); end
      endcase
      write_segment(seg_d);
      for (int n = 0; n < PHASE_LEN; n++) begin
        // hold the sender until the pipeline has drained completely
        if (n == PHASE_LEN / 2) wait_idle();
        if (n % 40 == 0) drain = ($urandom_range(2) == 0);
        while (req_q.size() >= 2) @(posedge clk_i);
        req_q.push_back(random_request(drain));
      end
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
